>>> rtl/core/itp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itp_pkg
// Shared types, codes and the precedence function of the infix to postfix
// converter.
// ---------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam int KIND_W  = 3;
    localparam int CODE_W  = 4;
    localparam int VALUE_W = 32;
    localparam int OKIND_W = 2;
    localparam int PREC_W  = 3;

    // input token kinds
    localparam logic [KIND_W-1:0] KIND_OPERAND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OPEN    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BINARY  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FUNC    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd5;

    // output token kinds
    localparam logic [OKIND_W-1:0] OKIND_OPERAND  = 2'd0;
    localparam logic [OKIND_W-1:0] OKIND_OPERATOR = 2'd1;
    localparam logic [OKIND_W-1:0] OKIND_END      = 2'd2;

    localparam logic [CODE_W-1:0] CODE_MAX   = 4'd10;
    localparam logic [CODE_W-1:0] PAREN_CODE = 4'd15;

    // sources of an emitted beat
    localparam logic [1:0] EMIT_OPERAND = 2'd0;
    localparam logic [1:0] EMIT_TOP     = 2'd1;
    localparam logic [1:0] EMIT_HOLD    = 2'd2;
    localparam logic [1:0] EMIT_END     = 2'd3;

    typedef struct packed {
        logic       tok_load;
        logic       push_code;
        logic       push_paren;
        logic       pop;
        logic       rd_top;
        logic       rd_below;
        logic       hold_load;
        logic       set_err;
        logic       emit;
        logic [1:0] emit_sel;
        logic       emit_last;
    } itp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              code_bad;
        logic              cnt_zero;
        logic              cnt_one;
        logic              top_paren;
        logic              top_pops;
        logic              out_free;
    } itp_stat_t;

    function automatic logic [PREC_W-1:0] prec_of(input logic [CODE_W-1:0] code);
        logic [PREC_W-1:0] p;
        if (code <= 4'd1)
            p = 3'd1;
        else if (code <= 4'd4)
            p = 3'd2;
        else if (code == 4'd5)
            p = 3'd3;
        else if (code <= CODE_MAX)
            p = 3'd4;
        else
            p = 3'd0;
        return p;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/itp_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itp_in_if
// Input token channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface itp_in_if;
    logic                          valid;
    logic                          ready;
    logic [itp_pkg::KIND_W-1:0]    op;
    logic [itp_pkg::CODE_W-1:0]    operator_code;
    logic [itp_pkg::VALUE_W-1:0]   operand_value;

    modport source (output valid, output op, output operator_code,
                    output operand_value, input ready);
    modport sink (input valid, input op, input operator_code,
                  input operand_value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/itp_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itp_out_if
// Postfix token channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface itp_out_if;
    logic                          valid;
    logic                          ready;
    logic [itp_pkg::OKIND_W-1:0]   token_kind;
    logic [itp_pkg::CODE_W-1:0]    out_operator;
    logic [itp_pkg::VALUE_W-1:0]   out_value;
    logic                          last;
    logic                          error;

    modport source (output valid, output token_kind, output out_operator,
                    output out_value, output last, output error, input ready);
    modport sink (input valid, input token_kind, input out_operator,
                  input out_value, input last, input error, output ready);
endinterface
`default_nettype wire

>>> rtl/core/itp_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itp_dpath
// Token register, operator stack memory, stack count, sticky error and
// output register.
// ---------------------------------------------------------------------------
module itp_dpath #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire itp_pkg::itp_cmd_t           cmd,
    output itp_pkg::itp_stat_t               stat,
    input  wire logic [itp_pkg::KIND_W-1:0]  in_op,
    input  wire logic [itp_pkg::CODE_W-1:0]  in_code,
    input  wire logic [itp_pkg::VALUE_W-1:0] in_value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [itp_pkg::OKIND_W-1:0]      out_kind,
    output logic [itp_pkg::CODE_W-1:0]       out_oper,
    output logic [itp_pkg::VALUE_W-1:0]      out_val,
    output logic                             out_last,
    output logic                             out_err
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [itp_pkg::CODE_W-1:0] stack_mem [STACK_DEPTH];

    logic [itp_pkg::KIND_W-1:0]  kind_reg;
    logic [itp_pkg::CODE_W-1:0]  code_reg;
    logic [itp_pkg::VALUE_W-1:0] value_reg;
    logic [itp_pkg::CODE_W-1:0]  rd_reg;
    logic [itp_pkg::CODE_W-1:0]  hold_reg;
    logic [CW-1:0]               count_reg, count_next;
    logic                        sticky_reg, sticky_next;
    logic                        out_valid_reg;
    logic [itp_pkg::OKIND_W-1:0] out_kind_reg;
    logic [itp_pkg::CODE_W-1:0]  out_oper_reg;
    logic [itp_pkg::VALUE_W-1:0] out_val_reg;
    logic                        out_last_reg;
    logic                        out_err_reg;

    logic                        push;
    logic                        full;
    logic [CW-1:0]               cnt_m1, cnt_m2;
    logic [AW-1:0]               rd_addr;
    logic [itp_pkg::CODE_W-1:0]  wr_data;
    logic                        rd_en;

    assign push    = cmd.push_code | cmd.push_paren;
    assign full    = (count_reg == CW'(STACK_DEPTH));
    assign cnt_m1  = count_reg - CW'(1);
    assign cnt_m2  = count_reg - CW'(2);
    assign rd_addr = cmd.rd_below ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
    assign rd_en   = cmd.rd_top | cmd.rd_below;
    assign wr_data = cmd.push_paren ? itp_pkg::PAREN_CODE : code_reg;

    // stack memory
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            stack_mem[count_reg[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tok_load)
        begin
            kind_reg  <= in_op;
            code_reg  <= in_code;
            value_reg <= in_value;
        end
        if (cmd.hold_load)
        begin
            hold_reg <= rd_reg;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        sticky_next = sticky_reg;
        if (push)
        begin
            if (full)
                sticky_next = 1'b1;
            else
                count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = cnt_m1;
        end
        if (cmd.set_err)
        begin
            sticky_next = 1'b1;
        end
        if (cmd.emit && cmd.emit_sel == itp_pkg::EMIT_END)
        begin
            sticky_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            sticky_reg <= sticky_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output beat
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_last_reg <= cmd.emit_last;
            case (cmd.emit_sel)
                itp_pkg::EMIT_OPERAND:
                begin
                    out_kind_reg <= itp_pkg::OKIND_OPERAND;
                    out_oper_reg <= '0;
                    out_val_reg  <= value_reg;
                    out_err_reg  <= 1'b0;
                end
                itp_pkg::EMIT_TOP:
                begin
                    out_kind_reg <= itp_pkg::OKIND_OPERATOR;
                    out_oper_reg <= rd_reg;
                    out_val_reg  <= '0;
                    out_err_reg  <= 1'b0;
                end
                itp_pkg::EMIT_HOLD:
                begin
                    out_kind_reg <= itp_pkg::OKIND_OPERATOR;
                    out_oper_reg <= hold_reg;
                    out_val_reg  <= '0;
                    out_err_reg  <= 1'b0;
                end
                default:
                begin
                    out_kind_reg <= itp_pkg::OKIND_END;
                    out_oper_reg <= '0;
                    out_val_reg  <= '0;
                    out_err_reg  <= sticky_reg;
                end
            endcase
        end
    end

    assign stat.kind      = kind_reg;
    assign stat.code_bad  = (code_reg > itp_pkg::CODE_MAX);
    assign stat.cnt_zero  = (count_reg == '0);
    assign stat.cnt_one   = (count_reg == CW'(1));
    assign stat.top_paren = (rd_reg == itp_pkg::PAREN_CODE);
    assign stat.top_pops  = (itp_pkg::prec_of(rd_reg) >= itp_pkg::prec_of(code_reg));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_oper  = out_oper_reg;
    assign out_val   = out_val_reg;
    assign out_last  = out_last_reg;
    assign out_err   = out_err_reg;

endmodule
`default_nettype wire

>>> rtl/core/itp_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itp_ctrl
// Sequencer of the converter: decodes a token and steps the stack pops.
// ---------------------------------------------------------------------------
module itp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire itp_pkg::itp_stat_t  stat,
    output itp_pkg::itp_cmd_t        cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_TOP    = 3'd2;
    localparam logic [2:0] S_LOOK   = 3'd3;
    localparam logic [2:0] S_END    = 3'd4;
    localparam logic [2:0] S_PUSH   = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.tok_load = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (stat.kind)
                    itp_pkg::KIND_OPERAND:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_sel  = itp_pkg::EMIT_OPERAND;
                            cmd.emit_last = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    itp_pkg::KIND_OPEN:
                    begin
                        cmd.push_paren = 1'b1;
                        state_next     = S_IDLE;
                    end
                    itp_pkg::KIND_CLOSE:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_top = 1'b1;
                            state_next = S_TOP;
                        end
                    end
                    itp_pkg::KIND_BINARY:
                    begin
                        if (stat.code_bad)
                            state_next = S_IDLE;
                        else if (stat.cnt_zero)
                        begin
                            cmd.push_code = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_top = 1'b1;
                            state_next = S_TOP;
                        end
                    end
                    itp_pkg::KIND_FUNC:
                    begin
                        cmd.push_code = !stat.code_bad;
                        state_next    = S_IDLE;
                    end
                    itp_pkg::KIND_END:
                    begin
                        if (stat.cnt_zero)
                            state_next = S_END;
                        else
                        begin
                            cmd.rd_top = 1'b1;
                            state_next = S_TOP;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TOP:
            begin
                case (stat.kind)
                    itp_pkg::KIND_CLOSE:
                    begin
                        if (stat.top_paren)
                        begin
                            cmd.pop    = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (stat.cnt_one)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_sel  = itp_pkg::EMIT_TOP;
                                cmd.emit_last = 1'b1;
                                cmd.pop       = 1'b1;
                                cmd.set_err   = 1'b1;
                                state_next    = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.hold_load = 1'b1;
                            cmd.pop       = 1'b1;
                            cmd.rd_below  = 1'b1;
                            state_next    = S_LOOK;
                        end
                    end
                    itp_pkg::KIND_BINARY:
                    begin
                        if (stat.top_paren || !stat.top_pops)
                        begin
                            cmd.push_code = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else if (stat.cnt_one)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_sel  = itp_pkg::EMIT_TOP;
                                cmd.emit_last = 1'b1;
                                cmd.pop       = 1'b1;
                                state_next    = S_PUSH;
                            end
                        end
                        else
                        begin
                            cmd.hold_load = 1'b1;
                            cmd.pop       = 1'b1;
                            cmd.rd_below  = 1'b1;
                            state_next    = S_LOOK;
                        end
                    end
                    itp_pkg::KIND_END:
                    begin
                        if (stat.top_paren || stat.out_free)
                        begin
                            cmd.pop = 1'b1;
                            if (stat.top_paren)
                                cmd.set_err = 1'b1;
                            else
                            begin
                                cmd.emit     = 1'b1;
                                cmd.emit_sel = itp_pkg::EMIT_TOP;
                            end
                            if (stat.cnt_one)
                                state_next = S_END;
                            else
                                cmd.rd_below = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LOOK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = itp_pkg::EMIT_HOLD;
                    if (stat.kind == itp_pkg::KIND_CLOSE)
                        cmd.emit_last = stat.top_paren;
                    else
                        cmd.emit_last = stat.top_paren || !stat.top_pops;
                    state_next = S_TOP;
                end
            end
            S_END:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = itp_pkg::EMIT_END;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_PUSH:
            begin
                cmd.push_code = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

>>> rtl/core/infix_to_postfix_converter_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: infix tokens in, postfix tokens out, one token
// a beat, with an operator stack held in a small memory.
// latency: a result beat is valid the cycle after the step that makes it
// S_DECIDE alone: operand, open, function, bad code, close/binary on empty stack
// binary, close: S_TOP, S_LOOK per pop; S_PUSH when a binary empties the stack
// end: S_TOP per entry, then S_END; close stops at its open paren or stack bottom
// a result beat left waiting on the output stalls the sequencer until it is taken
// reset: stack empty, error flag clear, output empty; stack memory not cleared
// ---------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    itp_in_if.sink     in_ch,
    itp_out_if.source  out_ch
);

    itp_pkg::itp_cmd_t  cmd;
    itp_pkg::itp_stat_t stat;

    itp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    itp_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (in_ch.op),
        .in_code   (in_ch.operator_code),
        .in_value  (in_ch.operand_value),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_kind  (out_ch.token_kind),
        .out_oper  (out_ch.out_operator),
        .out_val   (out_ch.out_value),
        .out_last  (out_ch.last),
        .out_err   (out_ch.error)
    );

endmodule
`default_nettype wire

>>> dv/tb_infix_to_postfix_converter_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_infix_to_postfix_converter_top
// Self-checking bench for the shunting-yard converter. Infix tokens are fed
// from a queue with random gaps. A behavioral operator stack inside the
// bench predicts the postfix beats of every accepted token. A monitor checks
// every output beat against the oldest prediction. Directed expressions cover
// the operand extremes, every operator, bad codes, reserved kinds, unmatched
// parentheses and stack overflow. Random well-formed expressions make up most
// of the remaining traffic, mixed with noise and deep nesting.
// ---------------------------------------------------------------------------
module tb_infix_to_postfix_converter_top;

    localparam int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF;
    localparam int TOKEN_TARGET = 160;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 80;
    localparam int MAX_PRINTS = 50;

    typedef logic [itp_pkg::KIND_W-1:0] kind_t;
    typedef logic [itp_pkg::CODE_W-1:0] code_t;
    typedef logic [itp_pkg::VALUE_W-1:0] value_t;

    localparam code_t OPC_ADD  = 4'd0;
    localparam code_t OPC_SUB  = 4'd1;
    localparam code_t OPC_MUL  = 4'd2;
    localparam code_t OPC_DIV  = 4'd3;
    localparam code_t OPC_MOD  = 4'd4;
    localparam code_t OPC_POW  = 4'd5;
    localparam code_t OPC_SIN  = 4'd6;
    localparam code_t OPC_COS  = 4'd7;
    localparam code_t OPC_TAN  = 4'd8;
    localparam code_t OPC_LOG  = 4'd9;
    localparam code_t OPC_SQRT = 4'd10;
    localparam code_t OPC_BAD  = 4'd11;

    localparam kind_t KIND_RSVD6 = 3'd6;
    localparam kind_t KIND_RSVD7 = 3'd7;

    typedef struct {
        bit     drain;
        kind_t  kind;
        code_t  code;
        value_t value;
    } infix_tok_t;

    typedef struct packed {
        logic [itp_pkg::OKIND_W-1:0] kind;
        code_t                       oper;
        value_t                      value;
        logic                        last;
        logic                        error;
    } postfix_tok_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    itp_in_if  in_ch ();
    itp_out_if out_ch ();

    infix_tok_t drv_tok = '{1'b0, itp_pkg::KIND_OPERAND, OPC_ADD, '0};
    logic       drv_valid = 1'b0;
    logic       rcv_ready = 1'b0;

    assign in_ch.valid         = drv_valid;
    assign in_ch.op            = drv_tok.kind;
    assign in_ch.operator_code = drv_tok.code;
    assign in_ch.operand_value = drv_tok.value;
    assign out_ch.ready        = rcv_ready;

    infix_to_postfix_converter_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    infix_tok_t   token_q [$];
    postfix_tok_t postfix_q [$];

    code_t op_stk [STACK_DEPTH];
    int    stk_cnt = 0;
    logic  expr_err = 1'b0;

    int   n_tokens = 0;
    int   taken_cnt = 0;
    int   err_cnt = 0;
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic hold_off = 1'b0;
    int   send_gap = 0;
    int   rcv_gap = 0;
    bit   send_burst = 1'b0;
    bit   rcv_burst = 1'b0;
    logic nxt_valid;
    logic nxt_ready;
    postfix_tok_t seen;
    postfix_tok_t want;

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input value_t got, input value_t exp);
        if (err_cnt < MAX_PRINTS)
            $display("%0t: %s got %0h want %0h", $time, what, got, exp);
        err_cnt++;
    endtask

    function automatic int rank_of(input code_t code);
        case (code)
            OPC_ADD, OPC_SUB:          return 1;
            OPC_MUL, OPC_DIV, OPC_MOD: return 2;
            OPC_POW:                   return 3;
            OPC_SIN, OPC_COS, OPC_TAN, OPC_LOG, OPC_SQRT: return 4;
            default:                   return 0;
        endcase
    endfunction

    function automatic postfix_tok_t mk_tok(input logic [itp_pkg::OKIND_W-1:0] kind,
                                            input code_t oper, input value_t value,
                                            input logic error);
        postfix_tok_t r;
        r.kind  = kind;
        r.oper  = oper;
        r.value = value;
        r.last  = 1'b0;
        r.error = error;
        return r;
    endfunction

    task automatic stk_push(input code_t code);
        if (stk_cnt < STACK_DEPTH)
        begin
            op_stk[stk_cnt] = code;
            stk_cnt++;
        end
        else
            expr_err = 1'b1;
    endtask

    task automatic predict_postfix(input infix_tok_t t);
        postfix_tok_t res [$];
        code_t        top;
        bit           found;
        int           own;
        case (t.kind)
            itp_pkg::KIND_OPERAND:
                res.push_back(mk_tok(itp_pkg::OKIND_OPERAND, OPC_ADD, t.value, 1'b0));
            itp_pkg::KIND_OPEN:
                stk_push(itp_pkg::PAREN_CODE);
            itp_pkg::KIND_CLOSE:
            begin
                found = 1'b0;
                while (stk_cnt > 0)
                begin
                    stk_cnt--;
                    top = op_stk[stk_cnt];
                    if (top == itp_pkg::PAREN_CODE)
                    begin
                        found = 1'b1;
                        break;
                    end
                    res.push_back(mk_tok(itp_pkg::OKIND_OPERATOR, top, '0, 1'b0));
                end
                if (!found)
                    expr_err = 1'b1;
            end
            itp_pkg::KIND_BINARY, itp_pkg::KIND_FUNC:
            begin
                if (t.code <= itp_pkg::CODE_MAX)
                begin
                    if (t.kind == itp_pkg::KIND_BINARY)
                    begin
                        own = rank_of(t.code);
                        while (stk_cnt > 0 && op_stk[stk_cnt-1] != itp_pkg::PAREN_CODE
                               && rank_of(op_stk[stk_cnt-1]) >= own)
                        begin
                            stk_cnt--;
                            res.push_back(mk_tok(itp_pkg::OKIND_OPERATOR, op_stk[stk_cnt],
                                                 '0, 1'b0));
                        end
                    end
                    stk_push(t.code);
                end
            end
            itp_pkg::KIND_END:
            begin
                while (stk_cnt > 0)
                begin
                    stk_cnt--;
                    top = op_stk[stk_cnt];
                    if (top == itp_pkg::PAREN_CODE)
                        expr_err = 1'b1;
                    else
                        res.push_back(mk_tok(itp_pkg::OKIND_OPERATOR, top, '0, 1'b0));
                end
                res.push_back(mk_tok(itp_pkg::OKIND_END, OPC_ADD, '0, expr_err));
                expr_err = 1'b0;
            end
            default: ;
        endcase
        if (res.size() > 0)
            res[res.size()-1].last = 1'b1;
        foreach (res[i])
            postfix_q.push_back(res[i]);
    endtask

    // stimulus builders
    task automatic add_tok(input kind_t kind, input code_t code, input value_t value);
        token_q.push_back(infix_tok_t'{1'b0, kind, code, value});
        n_tokens++;
    endtask

    task automatic add_drain();
        token_q.push_back(infix_tok_t'{1'b1, itp_pkg::KIND_OPERAND, OPC_ADD, '0});
    endtask

    function automatic code_t rand_code();
        return code_t'($urandom_range(0, 2**itp_pkg::CODE_W - 1));
    endfunction

    function automatic code_t rand_func();
        return code_t'($urandom_range(OPC_SIN, OPC_SQRT));
    endfunction

    task automatic add_expression(input int terms);
        int depth;
        depth = 0;
        for (int t = 0; t < terms; t++)
        begin
            while (depth < 6 && $urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 1))
                    add_tok(itp_pkg::KIND_FUNC, rand_func(), $urandom);
                add_tok(itp_pkg::KIND_OPEN, rand_code(), $urandom);
                depth++;
            end
            if ($urandom_range(0, 5) == 0)
                add_tok(itp_pkg::KIND_FUNC, rand_func(), $urandom);
            add_tok(itp_pkg::KIND_OPERAND, rand_code(), $urandom);
            while (depth > 0 && $urandom_range(0, 2) == 0)
            begin
                add_tok(itp_pkg::KIND_CLOSE, rand_code(), $urandom);
                depth--;
            end
            if (t < terms - 1)
                add_tok(itp_pkg::KIND_BINARY, code_t'($urandom_range(OPC_ADD, OPC_POW)),
                        $urandom);
        end
        while (depth > 0)
        begin
            add_tok(itp_pkg::KIND_CLOSE, rand_code(), $urandom);
            depth--;
        end
        add_tok(itp_pkg::KIND_END, rand_code(), $urandom);
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++)
            add_tok(kind_t'($urandom_range(itp_pkg::KIND_OPERAND, KIND_RSVD7)), rand_code(),
                    $urandom);
        if ($urandom_range(0, 1))
            add_tok(itp_pkg::KIND_END, rand_code(), $urandom);
    endtask

    task automatic add_nest(input int levels);
        for (int i = 0; i < levels; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                add_tok(itp_pkg::KIND_FUNC, rand_func(), $urandom);
            else
                add_tok(itp_pkg::KIND_OPEN, rand_code(), $urandom);
            if ($urandom_range(0, 3) == 0)
            begin
                add_tok(itp_pkg::KIND_OPERAND, rand_code(), $urandom);
                add_tok(itp_pkg::KIND_BINARY, code_t'($urandom_range(OPC_ADD, OPC_POW)),
                        $urandom);
            end
        end
        add_tok(itp_pkg::KIND_OPERAND, rand_code(), $urandom);
        for (int i = 0; i < levels; i++)
            add_tok(itp_pkg::KIND_CLOSE, rand_code(), $urandom);
        add_tok(itp_pkg::KIND_END, rand_code(), $urandom);
    endtask

    // handshake tracking and prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire  <= in_ch.valid && in_ch.ready;
            out_fire <= out_ch.valid && out_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                predict_postfix(drv_tok);
                taken_cnt++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                seen = '{out_ch.token_kind, out_ch.out_operator, out_ch.out_value,
                         out_ch.last, out_ch.error};
                if (postfix_q.size() == 0)
                    report_mismatch("unexpected beat, out_value", seen.value, '0);
                else
                begin
                    want = postfix_q.pop_front();
                    if (seen.kind !== want.kind)
                        report_mismatch("token_kind", value_t'(seen.kind),
                                        value_t'(want.kind));
                    if (seen.oper !== want.oper)
                        report_mismatch("out_operator", value_t'(seen.oper),
                                        value_t'(want.oper));
                    if (seen.value !== want.value)
                        report_mismatch("out_value", seen.value, want.value);
                    if (seen.last !== want.last)
                        report_mismatch("last", value_t'(seen.last), value_t'(want.last));
                    if (seen.error !== want.error)
                        report_mismatch("error", value_t'(seen.error), value_t'(want.error));
                end
            end
        end
    end

    // token driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            nxt_valid = drv_valid;
            if (in_fire)
                nxt_valid = 1'b0;
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (token_q.size() > 0)
                begin
                    if (token_q[0].drain)
                    begin
                        if (postfix_q.size() == 0)
                            void'(token_q.pop_front());
                    end
                    else
                    begin
                        drv_tok <= token_q.pop_front();
                        nxt_valid = 1'b1;
                        if ($urandom_range(0, 15) == 0)
                            send_burst = !send_burst;
                        send_gap = send_burst ? 0 : $urandom_range(0, 9);
                    end
                end
            end
            drv_valid <= nxt_valid;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                if ($urandom_range(0, 15) == 0)
                    rcv_burst = !rcv_burst;
                rcv_gap = rcv_burst ? 0 : $urandom_range(0, 9);
            end
            if (hold_off)
                nxt_ready = 1'b0;
            else if (rcv_gap > 0)
            begin
                nxt_ready = 1'b0;
                rcv_gap--;
            end
            else
                nxt_ready = 1'b1;
            rcv_ready <= nxt_ready;
        end
    end

    // long receiver stall so the stack path backs up
    initial
    begin
        while (taken_cnt < HOLD_AFTER)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        // operand extremes and a nested expression over the binary operators, sin and cos
        add_tok(itp_pkg::KIND_OPERAND, OPC_ADD, 32'h0000_0000);
        add_tok(itp_pkg::KIND_BINARY, OPC_ADD, '0);
        add_tok(itp_pkg::KIND_OPERAND, OPC_ADD, 32'hFFFF_FFFF);
        add_tok(itp_pkg::KIND_BINARY, OPC_MUL, '0);
        add_tok(itp_pkg::KIND_OPEN, OPC_ADD, '0);
        add_tok(itp_pkg::KIND_OPERAND, OPC_ADD, 32'hA5A5_A5A5);
        add_tok(itp_pkg::KIND_BINARY, OPC_SUB, '0);
        add_tok(itp_pkg::KIND_FUNC, OPC_SIN, '0);
        add_tok(itp_pkg::KIND_OPEN, OPC_ADD, '0);
        add_tok(itp_pkg::KIND_OPERAND, OPC_ADD, 32'h5A5A_5A5A);
        add_tok(itp_pkg::KIND_BINARY, OPC_POW, '0);
        add_tok(itp_pkg::KIND_OPERAND, OPC_ADD, 32'h0000_0001);
        add_tok(itp_pkg::KIND_BINARY, OPC_POW, '0);
        add_tok(itp_pkg::KIND_FUNC, OPC_COS, '0);
        add_tok(itp_pkg::KIND_CLOSE, OPC_ADD, '0);
        add_tok(itp_pkg::KIND_BINARY, OPC_DIV, '0);
        add_tok(itp_pkg::KIND_BINARY, OPC_MOD, '0);
        // bad codes and reserved kinds are dropped
        add_tok(itp_pkg::KIND_BINARY, OPC_BAD, '1);
        add_tok(itp_pkg::KIND_FUNC, itp_pkg::PAREN_CODE, '1);
        add_tok(KIND_RSVD6, OPC_TAN, '1);
        add_tok(KIND_RSVD7, OPC_LOG, '1);
        // mixed kind and code, unmatched close
        add_tok(itp_pkg::KIND_FUNC, OPC_ADD, '0);
        add_tok(itp_pkg::KIND_BINARY, OPC_SQRT, '0);
        add_tok(itp_pkg::KIND_FUNC, OPC_TAN, '0);
        add_tok(itp_pkg::KIND_FUNC, OPC_LOG, '0);
        add_tok(itp_pkg::KIND_CLOSE, OPC_ADD, '0);
        add_tok(itp_pkg::KIND_CLOSE, OPC_ADD, '0);
        // open left over at end, then an empty expression
        add_tok(itp_pkg::KIND_OPEN, OPC_ADD, '0);
        add_tok(itp_pkg::KIND_END, OPC_ADD, '0);
        add_tok(itp_pkg::KIND_END, OPC_ADD, '0);
        add_drain();

        // stack overflow, deep nesting, then mostly well-formed expressions
        add_nest(STACK_DEPTH + 4);
        add_nest($urandom_range(20, STACK_DEPTH - 1));
        while (n_tokens < TOKEN_TARGET)
        begin
            case ($urandom_range(0, 9))
                7, 8:    add_noise($urandom_range(3, 10));
                9:       add_nest($urandom_range(4, 12));
                default: add_expression($urandom_range(1, 8));
            endcase
            if (n_tokens > TOKEN_TARGET / 2 && n_tokens < TOKEN_TARGET / 2 + 12)
                add_drain();
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (token_q.size() > 0 || drv_valid || postfix_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/itp_pkg.sv
rtl/core/itp_in_if.sv
rtl/core/itp_out_if.sv
rtl/core/itp_dpath.sv
rtl/core/itp_ctrl.sv
rtl/core/infix_to_postfix_converter_top.sv
dv/tb_infix_to_postfix_converter_top.sv
